// ===== design/ijsc_pkg.sv =====
// shared types, constants and hue helpers for the intake jam and sort controller
package ijsc_pkg;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_IN   = 3'd1,
    MODE_OUT  = 3'd2,
    MODE_JAM  = 3'd3,
    MODE_SPIN = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    CFG_TEAM_COLOR    = 3'd0,
    CFG_ARM_LOADING   = 3'd1,
    CFG_SORTER_HOLD   = 3'd2,
    CFG_JAM_TICKS     = 3'd3,
    CFG_ARM_JAM_TICKS = 3'd4,
    CFG_SORT_TICKS    = 3'd5,
    CFG_SPIN_TIMEOUT  = 3'd6
  } cfg_idx_e;

  localparam logic [1:0] TEAM_RED  = 2'd0;
  localparam logic [1:0] TEAM_BLUE = 2'd1;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic signed [10:0] SPEED_STALL = 11'sd5;
  localparam logic signed [7:0]  DRIVE_FULL  = 8'sd127;
  localparam logic signed [7:0]  DRIVE_SPIN  = 8'sd69;
  localparam logic signed [7:0]  DRIVE_STOP  = 8'sd0;

  localparam logic [7:0] PROX_NEAR      = 8'd200;
  localparam logic [8:0] HUE_RED_LO     = 9'd30;
  localparam logic [8:0] HUE_RED_HI     = 9'd300;
  localparam logic [8:0] HUE_BLUE_LO    = 9'd180;
  localparam logic [8:0] HUE_BLUE_HI    = 9'd330;
  localparam logic [8:0] HUE_SORT_LO    = 9'd215;
  localparam logic [8:0] HUE_SORT_HI    = 9'd290;

  typedef struct packed {
    logic [1:0] team_color;
    logic       arm_loading;
    logic       sorter_hold;
    logic [7:0] jam_ticks;
    logic [9:0] arm_jam_ticks;
    logic [7:0] sort_ticks;
    logic [9:0] spin_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic               func;
    logic [2:0]         new_mode;
    logic signed [10:0] motor_speed;
    logic [8:0]         hue_front;
    logic [8:0]         hue_back;
    logic [7:0]         proximity;
  } item_t;

  typedef struct packed {
    logic signed [7:0] motor_drive;
    logic              sorter_extend;
    logic [2:0]        mode_now;
    logic              jam_check_on;
  } result_t;

  function automatic logic red_hue(input logic [8:0] h);
    return (h < HUE_RED_LO) || (h > HUE_RED_HI);
  endfunction

  function automatic logic blue_hue(input logic [8:0] h);
    return (h > HUE_BLUE_LO) && (h < HUE_BLUE_HI);
  endfunction

endpackage

// ===== design/ijsc_core.sv =====
// controller state and the per-request tick / command update
module ijsc_core import ijsc_pkg::*; #(
  parameter int unsigned REVERSE_TICKS = 25,
  parameter int unsigned TIMER_BITS    = 10
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  localparam int unsigned RH_W  = $clog2(REVERSE_TICKS + 1);
  localparam int unsigned CMP_W = (TIMER_BITS > 10) ? TIMER_BITS : 10;

  mode_e                 mode_q, mode_d;
  logic                  stall_seen_q, stall_seen_d;
  logic [TIMER_BITS-1:0] stall_cnt_q, stall_cnt_d;
  logic                  jam_en_q, jam_en_d;
  logic [TIMER_BITS-1:0] sort_cnt_q, sort_cnt_d;
  logic                  sort_armed_q, sort_armed_d;
  logic                  spin_active_q, spin_active_d;
  logic [TIMER_BITS-1:0] spin_cnt_q, spin_cnt_d;
  logic [RH_W-1:0]       rev_hold_q, rev_hold_d;
  logic                  sorter_q, sorter_d;
  logic signed [7:0]     drive;
  logic                  near, match, ring, stalled;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
    return (v == '1) ? v : v + TIMER_BITS'(1);
  endfunction

  assign near    = item_i.proximity > PROX_NEAR;
  assign stalled = (item_i.motor_speed < SPEED_STALL) && (item_i.motor_speed > -SPEED_STALL);

  always_comb begin
    mode_d        = mode_q;
    stall_seen_d  = stall_seen_q;
    stall_cnt_d   = stall_cnt_q;
    jam_en_d      = jam_en_q;
    sort_cnt_d    = sort_cnt_q;
    sort_armed_d  = sort_armed_q;
    spin_active_d = spin_active_q;
    spin_cnt_d    = spin_cnt_q;
    rev_hold_d    = rev_hold_q;
    sorter_d      = sorter_q;
    drive         = DRIVE_STOP;
    match         = 1'b0;
    ring          = 1'b0;

    if (item_i.func) begin
      if (item_i.new_mode <= MODE_SPIN) begin
        mode_d     = mode_e'(item_i.new_mode);
        rev_hold_d = '0;
      end
    end else begin
      // time advances on every tick, held or not
      if (stall_seen_q)  stall_cnt_d = sat_inc(stall_cnt_q);
      if (sort_armed_q)  sort_cnt_d  = sat_inc(sort_cnt_q);
      if (spin_active_q) spin_cnt_d  = sat_inc(spin_cnt_q);

      if (rev_hold_q != '0) begin
        drive      = -DRIVE_FULL;
        rev_hold_d = rev_hold_q - RH_W'(1);
        if (rev_hold_q == RH_W'(1)) mode_d = MODE_IN;
      end else begin
        if (jam_en_q) begin
          if (stalled && (mode_q != MODE_IDLE)) begin
            if (!stall_seen_q) begin
              stall_seen_d = 1'b1;
              stall_cnt_d  = '0;
            end
            if (cfg_i.arm_loading) begin
              if (CMP_W'(stall_cnt_d) > CMP_W'(cfg_i.arm_jam_ticks)) mode_d = MODE_IDLE;
            end else begin
              if (CMP_W'(stall_cnt_d) > CMP_W'(cfg_i.jam_ticks)) mode_d = MODE_JAM;
            end
          end else begin
            stall_seen_d = 1'b0;
            stall_cnt_d  = '0;
          end
        end

        // color sorter, skipped while spinning
        if (mode_d != MODE_SPIN) begin
          if (cfg_i.team_color == TEAM_BLUE) begin
            match = red_hue(item_i.hue_front) && near;
          end else if (cfg_i.team_color == TEAM_RED) begin
            match = (item_i.hue_front > HUE_SORT_LO) && (item_i.hue_front < HUE_SORT_HI)
                    && near;
          end
          if (match) begin
            sort_cnt_d   = '0;
            sort_armed_d = 1'b1;
          end
          if (!cfg_i.sorter_hold) begin
            sorter_d = sort_armed_d && (CMP_W'(sort_cnt_d) < CMP_W'(cfg_i.sort_ticks));
          end
        end

        unique case (mode_d)
          MODE_IN:  drive = DRIVE_FULL;
          MODE_OUT: drive = -DRIVE_FULL;
          MODE_JAM: begin
            drive = -DRIVE_FULL;
            if (cfg_i.arm_loading) mode_d = MODE_IDLE;
            else rev_hold_d = RH_W'(REVERSE_TICKS);
          end
          MODE_SPIN: begin
            if (!spin_active_q) begin
              spin_active_d = 1'b1;
              spin_cnt_d    = '0;
            end
            drive    = DRIVE_SPIN;
            jam_en_d = 1'b0;
            if (cfg_i.team_color == TEAM_RED) begin
              ring = red_hue(item_i.hue_front) && red_hue(item_i.hue_back) && near;
            end else if (cfg_i.team_color == TEAM_BLUE) begin
              ring = blue_hue(item_i.hue_front) && blue_hue(item_i.hue_back) && near;
            end
            if (ring || (CMP_W'(spin_cnt_d) >= CMP_W'(cfg_i.spin_timeout_ticks))) begin
              spin_active_d = 1'b0;
              spin_cnt_d    = '0;
              mode_d        = MODE_IDLE;
              jam_en_d      = 1'b1;
            end
          end
          default: drive = DRIVE_STOP;
        endcase
      end
    end
  end

  always_comb begin
    res_o.motor_drive   = drive;
    res_o.sorter_extend = sorter_d;
    res_o.mode_now      = mode_d;
    res_o.jam_check_on  = jam_en_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_IDLE;
      stall_seen_q  <= 1'b0;
      stall_cnt_q   <= '0;
      jam_en_q      <= 1'b1;
      sort_cnt_q    <= '0;
      sort_armed_q  <= 1'b0;
      spin_active_q <= 1'b0;
      spin_cnt_q    <= '0;
      rev_hold_q    <= '0;
      sorter_q      <= 1'b0;
    end else if (fire_i) begin
      mode_q        <= mode_d;
      stall_seen_q  <= stall_seen_d;
      stall_cnt_q   <= stall_cnt_d;
      jam_en_q      <= jam_en_d;
      sort_cnt_q    <= sort_cnt_d;
      sort_armed_q  <= sort_armed_d;
      spin_active_q <= spin_active_d;
      spin_cnt_q    <= spin_cnt_d;
      rev_hold_q    <= rev_hold_d;
      sorter_q      <= sorter_d;
    end
  end

endmodule

// ===== design/intake_jam_sort_controller.sv =====
// top level of the intake jam and color sort controller
//
// usage:
//  - input channel (in_valid_i / in_ready_o) carries one request per tick or
//    mode command: func_i 0 is a 10 ms tick with sensor readings, 1 sets the
//    mode from new_mode_i
//  - output channel (out_valid_o / out_ready_i) returns exactly one result per
//    request: motor drive, sorter level, mode and jam detection flag
//  - config channel (cfg_valid_i / cfg_ready_o) writes register cfg_index_i
//    with cfg_data_i; always ready, write only while the block is idle
// path: a request is held in the input register, the tick logic runs
//  between it and the result register, and the result shows once it is
//  loaded into the result register
// throughput: one request per cycle while out_ready_i stays high; the whole
//  update is a handful of compares and saturating counter steps, all combinational
// stall: the result register holds while out_ready_i is low, the input
//  register still takes one more request, then in_ready_o drops
// reset: async active low; mode idle, counters zero, jam detection on,
//  registers back to their defaults, both channels empty
module intake_jam_sort_controller import ijsc_pkg::*; #(
  parameter int unsigned REVERSE_TICKS = 25,
  parameter int unsigned TIMER_BITS    = 10
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  func_i,
  input  logic [2:0]            new_mode_i,
  input  logic signed [10:0]    motor_speed_i,
  input  logic [8:0]            hue_front_i,
  input  logic [8:0]            hue_back_i,
  input  logic [7:0]            proximity_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic signed [7:0]     motor_drive_o,
  output logic                  sorter_extend_o,
  output logic [2:0]            mode_now_o,
  output logic                  jam_check_on_o,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  item_t   item_q;
  logic    item_valid_q;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    advance;

  // request moves from input register to result register
  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.team_color         <= 2'd0;
      cfg_q.arm_loading        <= 1'b0;
      cfg_q.sorter_hold        <= 1'b0;
      cfg_q.jam_ticks          <= 8'd15;
      cfg_q.arm_jam_ticks      <= 10'd100;
      cfg_q.sort_ticks         <= 8'd23;
      cfg_q.spin_timeout_ticks <= 10'd500;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TEAM_COLOR:    cfg_q.team_color         <= cfg_data_i[1:0];
        CFG_ARM_LOADING:   cfg_q.arm_loading        <= cfg_data_i[0];
        CFG_SORTER_HOLD:   cfg_q.sorter_hold        <= cfg_data_i[0];
        CFG_JAM_TICKS:     cfg_q.jam_ticks          <= cfg_data_i[7:0];
        CFG_ARM_JAM_TICKS: cfg_q.arm_jam_ticks      <= cfg_data_i[9:0];
        CFG_SORT_TICKS:    cfg_q.sort_ticks         <= cfg_data_i[7:0];
        CFG_SPIN_TIMEOUT:  cfg_q.spin_timeout_ticks <= cfg_data_i[9:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  // input payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.func        <= func_i;
      item_q.new_mode    <= new_mode_i;
      item_q.motor_speed <= motor_speed_i;
      item_q.hue_front   <= hue_front_i;
      item_q.hue_back    <= hue_back_i;
      item_q.proximity   <= proximity_i;
    end
  end

  // controller state and tick logic, state commits on advance
  ijsc_core #(
    .REVERSE_TICKS (REVERSE_TICKS),
    .TIMER_BITS    (TIMER_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .res_o  (res_d)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign motor_drive_o   = res_q.motor_drive;
  assign sorter_extend_o = res_q.sorter_extend;
  assign mode_now_o      = res_q.mode_now;
  assign jam_check_on_o  = res_q.jam_check_on;

endmodule

// ===== design/ijsc_checker.sv =====
// port level checks for the intake jam and sort controller, bound to the top
module ijsc_checker import ijsc_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic signed [7:0]     motor_drive_o,
  input logic                  sorter_extend_o,
  input logic [2:0]            mode_now_o,
  input logic                  jam_check_on_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(motor_drive_o)
      && $stable(sorter_extend_o) && $stable(mode_now_o) && $stable(jam_check_on_o))
    else $error("stalled result changed");

  // only the four drive levels appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (motor_drive_o == DRIVE_STOP) || (motor_drive_o == DRIVE_FULL)
      || (motor_drive_o == -DRIVE_FULL) || (motor_drive_o == DRIVE_SPIN))
    else $error("illegal motor drive");

  // spin drive: still spinning with detection off, or just finished into idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (motor_drive_o == DRIVE_SPIN) |->
      ((mode_now_o == MODE_SPIN) && !jam_check_on_o)
      || ((mode_now_o == MODE_IDLE) && jam_check_on_o))
    else $error("spin drive with wrong mode");

  // full forward drive only in intake mode
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (motor_drive_o == DRIVE_FULL) |-> (mode_now_o == MODE_IN))
    else $error("forward drive outside intake mode");

  // jam mode reverses after a tick and stops right after a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (mode_now_o == MODE_JAM) |->
      (motor_drive_o == DRIVE_STOP) || (motor_drive_o == -DRIVE_FULL))
    else $error("jam mode with wrong drive");

endmodule

bind intake_jam_sort_controller ijsc_checker u_ijsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .motor_drive_o   (motor_drive_o),
  .sorter_extend_o (sorter_extend_o),
  .mode_now_o      (mode_now_o),
  .jam_check_on_o  (jam_check_on_o)
);

// ===== dv/testbench.sv =====
// self-checking testbench for the intake jam and color sort controller
`timescale 1ns / 1ps

module testbench;
  import ijsc_pkg::*;

  localparam int          QUIET_LIMIT = 2000;
  localparam logic [5:0]  REV_TICKS   = 6'd25;
  localparam logic [9:0]  CNT_MAX     = 10'h3FF;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // request channel
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic               func_i        = 1'b0;
  logic [2:0]         new_mode_i    = '0;
  logic signed [10:0] motor_speed_i = '0;
  logic [8:0]         hue_front_i   = '0;
  logic [8:0]         hue_back_i    = '0;
  logic [7:0]         proximity_i   = '0;

  // result channel
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic signed [7:0]  motor_drive_o;
  logic               sorter_extend_o;
  logic [2:0]         mode_now_o;
  logic               jam_check_on_o;

  // register write channel
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  intake_jam_sort_controller u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .new_mode_i      (new_mode_i),
    .motor_speed_i   (motor_speed_i),
    .hue_front_i     (hue_front_i),
    .hue_back_i      (hue_back_i),
    .proximity_i     (proximity_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .motor_drive_o   (motor_drive_o),
    .sorter_extend_o (sorter_extend_o),
    .mode_now_o      (mode_now_o),
    .jam_check_on_o  (jam_check_on_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------
  // controller shadow: registers and state as the block should hold them
  // ------------------------------------------------------------------
  cfg_t       cfg_sh;
  mode_e      md;
  logic       stall_seen, jam_on, sort_armed, spin_on, sorter_lvl;
  logic [9:0] stall_cnt, sort_since, spin_cnt;
  logic [5:0] rev_hold;

  item_t   request_q[$];         // requests not yet offered to the block
  result_t intake_results_q[$];  // predicted outputs, oldest first
  int      gen_cnt;
  int      err_cnt = 0;

  function automatic logic hue_reddish(input logic [8:0] h);
    return (h < HUE_RED_LO) || (h > HUE_RED_HI);
  endfunction

  function automatic logic hue_bluish(input logic [8:0] h);
    return (h > HUE_BLUE_LO) && (h < HUE_BLUE_HI);
  endfunction

  // saturating timers, each only while its start mark is set
  task automatic run_timers();
    if (stall_seen) stall_cnt = (stall_cnt == CNT_MAX) ? CNT_MAX : stall_cnt + 10'd1;
    if (sort_armed) sort_since = (sort_since == CNT_MAX) ? CNT_MAX : sort_since + 10'd1;
    if (spin_on) spin_cnt = (spin_cnt == CNT_MAX) ? CNT_MAX : spin_cnt + 10'd1;
  endtask

  // one accepted request: update the shadow and queue the expected output
  task automatic intake_step(input item_t it);
    result_t r;
    logic    near, hit, ring;
    r.motor_drive = DRIVE_STOP;
    hit  = 1'b0;
    ring = 1'b0;
    near = it.proximity > PROX_NEAR;
    if (it.func) begin
      // commands above spin-until are dropped, a valid one ends any reverse hold
      if (it.new_mode <= MODE_SPIN) begin
        md       = mode_e'(it.new_mode);
        rev_hold = '0;
      end
    end else if (rev_hold != '0) begin
      // reverse hold: timers only, sorter frozen, no stall check
      run_timers();
      r.motor_drive = -DRIVE_FULL;
      rev_hold = rev_hold - 6'd1;
      if (rev_hold == '0) md = MODE_IN;
    end else begin
      run_timers();
      if (jam_on) begin
        if (it.motor_speed > -SPEED_STALL && it.motor_speed < SPEED_STALL &&
            md != MODE_IDLE) begin
          if (!stall_seen) begin
            stall_seen = 1'b1;
            stall_cnt  = '0;
          end
          if (cfg_sh.arm_loading) begin
            if (stall_cnt > cfg_sh.arm_jam_ticks) md = MODE_IDLE;
          end else if (stall_cnt > {2'b00, cfg_sh.jam_ticks}) begin
            md = MODE_JAM;
          end
        end else begin
          stall_seen = 1'b0;
          stall_cnt  = '0;
        end
      end
      if (md != MODE_SPIN) begin
        // sort away the opposing color; skills and team 3 never match
        if (cfg_sh.team_color == TEAM_BLUE) begin
          hit = hue_reddish(it.hue_front) && near;
        end else if (cfg_sh.team_color == TEAM_RED) begin
          hit = it.hue_front > HUE_SORT_LO && it.hue_front < HUE_SORT_HI && near;
        end
        if (hit) begin
          sort_since = '0;
          sort_armed = 1'b1;
        end
        if (!cfg_sh.sorter_hold) begin
          sorter_lvl = sort_armed && (sort_since < {2'b00, cfg_sh.sort_ticks});
        end
      end
      case (md)
        MODE_IN:  r.motor_drive = DRIVE_FULL;
        MODE_OUT: r.motor_drive = -DRIVE_FULL;
        MODE_JAM: begin
          r.motor_drive = -DRIVE_FULL;
          if (cfg_sh.arm_loading) md = MODE_IDLE;
          else rev_hold = REV_TICKS;
        end
        MODE_SPIN: begin
          if (!spin_on) begin
            spin_on  = 1'b1;
            spin_cnt = '0;
          end
          r.motor_drive = DRIVE_SPIN;
          jam_on = 1'b0;
          if (cfg_sh.team_color == TEAM_RED) begin
            ring = hue_reddish(it.hue_front) && hue_reddish(it.hue_back) && near;
          end else if (cfg_sh.team_color == TEAM_BLUE) begin
            ring = hue_bluish(it.hue_front) && hue_bluish(it.hue_back) && near;
          end
          if (ring || spin_cnt >= cfg_sh.spin_timeout_ticks) begin
            spin_on  = 1'b0;
            spin_cnt = '0;
            md       = MODE_IDLE;
            jam_on   = 1'b1;
          end
        end
        default: r.motor_drive = DRIVE_STOP;
      endcase
    end
    r.sorter_extend = sorter_lvl;
    r.mode_now      = md;
    r.jam_check_on  = jam_on;
    intake_results_q.push_back(r);
  endtask

  // ------------------------------------------------------------------
  // idle draws: stretches of calm (no waits) alternate with random waits
  // ------------------------------------------------------------------
  int   in_run_left  = 0, out_run_left = 0;
  logic in_run_calm  = 1'b0, out_run_calm = 1'b0;

  function automatic int draw_wait(inout int run_left, inout logic run_calm);
    if (run_left == 0) begin
      run_left = $urandom_range(20, 80);
      run_calm = ($urandom_range(0, 3) == 0);
    end
    run_left--;
    if (run_calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  // ------------------------------------------------------------------
  // request driver
  // ------------------------------------------------------------------
  item_t cur_req;
  int    gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        intake_step(cur_req);
        gap_left = draw_wait(in_run_left, in_run_calm);
      end
      if (in_valid_i && !in_ready_o) begin
        // request still pending, hold it
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (request_q.size() != 0) begin
        cur_req = request_q.pop_front();
        in_valid_i    <= 1'b1;
        func_i        <= cur_req.func;
        new_mode_i    <= cur_req.new_mode;
        motor_speed_i <= cur_req.motor_speed;
        hue_front_i   <= cur_req.hue_front;
        hue_back_i    <= cur_req.hue_back;
        proximity_i   <= cur_req.proximity;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // result monitor and checker
  // ------------------------------------------------------------------
  int      hold_cnt;
  result_t want_r, got_r;
  logic    bad;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt = 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_r.motor_drive   = motor_drive_o;
        got_r.sorter_extend = sorter_extend_o;
        got_r.mode_now      = mode_now_o;
        got_r.jam_check_on  = jam_check_on_o;
        if (intake_results_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("%0t: result with nothing expected", $time);
        end else begin
          want_r = intake_results_q.pop_front();
          bad = (got_r.motor_drive !== want_r.motor_drive) ||
                (got_r.sorter_extend !== want_r.sorter_extend) ||
                (got_r.mode_now !== want_r.mode_now) ||
                (got_r.jam_check_on !== want_r.jam_check_on);
          if (bad) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("%0t: mismatch drive %0d/%0d sorter %0b/%0b mode %0d/%0d jam %0b/%0b",
                       $time, want_r.motor_drive, got_r.motor_drive,
                       want_r.sorter_extend, got_r.sorter_extend,
                       want_r.mode_now, got_r.mode_now,
                       want_r.jam_check_on, got_r.jam_check_on);
            end
          end
        end
        hold_cnt = draw_wait(out_run_left, out_run_calm);
      end else if (hold_cnt > 0) begin
        hold_cnt--;
      end
      out_ready_i <= (hold_cnt == 0);
    end
  end

  // ------------------------------------------------------------------
  // watchdog: too long without any handshake ends the run
  // ------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("[intake_jam_sort_controller] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------
  // stimulus helpers
  // ------------------------------------------------------------------
  function automatic int any_speed();
    int s;
    if ($urandom_range(0, 2) == 0) begin
      s = $urandom_range(0, 8);
      return s - 4;
    end
    s = $urandom_range(0, 1200);
    return s - 600;
  endfunction

  function automatic int stall_speed();
    int s;
    s = $urandom_range(0, 8);
    return s - 4;
  endfunction

  function automatic int moving_speed();
    int s;
    s = $urandom_range(5, 600);
    return $urandom_range(0, 1) ? s : -s;
  endfunction

  function automatic int plain_hue();
    return $urandom_range(0, 359);
  endfunction

  // hue the sorter should kick out for this team
  function automatic int sort_hue(input logic [1:0] tc);
    if (tc == TEAM_BLUE) begin
      return $urandom_range(0, 1) ? $urandom_range(0, 29) : $urandom_range(301, 359);
    end
    return $urandom_range(216, 289);
  endfunction

  // hue of the team's own ring, ends spin-until
  function automatic int ring_hue(input logic [1:0] tc);
    if (tc == TEAM_RED) begin
      return $urandom_range(0, 1) ? $urandom_range(0, 29) : $urandom_range(301, 359);
    end
    if (tc == TEAM_BLUE) return $urandom_range(181, 329);
    return plain_hue();
  endfunction

  function automatic item_t noise_item();
    item_t it;
    int    s;
    s = $urandom_range(0, 1200);
    s = s - 600;
    it.func        = 1'($urandom_range(0, 1));
    it.new_mode    = 3'($urandom_range(0, 7));
    it.motor_speed = s[10:0];
    it.hue_front   = 9'($urandom_range(0, 359));
    it.hue_back    = 9'($urandom_range(0, 359));
    it.proximity   = 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic item_t cmd_item(input logic [2:0] m);
    item_t it;
    it = noise_item();
    it.func     = 1'b1;
    it.new_mode = m;
    return it;
  endfunction

  function automatic item_t tick_item(input int spd, input int hf, input int hb,
                                      input int prox);
    item_t it;
    it = noise_item();
    it.func        = 1'b0;
    it.motor_speed = spd[10:0];
    it.hue_front   = hf[8:0];
    it.hue_back    = hb[8:0];
    it.proximity   = prox[7:0];
    return it;
  endfunction

  // ignored commands do not count toward the phase size
  task automatic push_req(input item_t it);
    request_q.push_back(it);
    if (!(it.func && it.new_mode > MODE_SPIN)) gen_cnt++;
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [9:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_TEAM_COLOR:    cfg_sh.team_color         = val[1:0];
      CFG_ARM_LOADING:   cfg_sh.arm_loading        = val[0];
      CFG_SORTER_HOLD:   cfg_sh.sorter_hold        = val[0];
      CFG_JAM_TICKS:     cfg_sh.jam_ticks          = val[7:0];
      CFG_ARM_JAM_TICKS: cfg_sh.arm_jam_ticks      = val[9:0];
      CFG_SORT_TICKS:    cfg_sh.sort_ticks         = val[7:0];
      CFG_SPIN_TIMEOUT:  cfg_sh.spin_timeout_ticks = val[9:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [1:0] tc, input logic arm, input logic hold,
                           input logic [9:0] jam, input logic [9:0] arm_jam,
                           input logic [9:0] srt, input logic [9:0] spin_to);
    write_reg(CFG_TEAM_COLOR, {8'd0, tc});
    write_reg(CFG_ARM_LOADING, {9'd0, arm});
    write_reg(CFG_SORTER_HOLD, {9'd0, hold});
    write_reg(CFG_JAM_TICKS, jam);
    write_reg(CFG_ARM_JAM_TICKS, arm_jam);
    write_reg(CFG_SORT_TICKS, srt);
    write_reg(CFG_SPIN_TIMEOUT, spin_to);
  endtask

  // block is idle once every request is taken and every result is back
  task automatic wait_drain();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || intake_results_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // random phase: mostly well-formed mode runs with random content, some noise
  task automatic run_phase(input int n_req);
    int         lim, len, j;
    logic [1:0] tc;
    @(negedge clk_i);
    gen_cnt = 0;
    tc = cfg_sh.team_color;
    while (gen_cnt < n_req) begin
      case ($urandom_range(0, 9))
        0: begin
          len = $urandom_range(1, 6);
          for (j = 0; j < len; j++) push_req(noise_item());
        end
        1, 2: begin
          // run, stall long enough to trip the limit or not, then recover
          push_req(cmd_item($urandom_range(0, 1) ? MODE_IN : MODE_OUT));
          len = $urandom_range(0, 4);
          for (j = 0; j < len; j++) begin
            push_req(tick_item(moving_speed(), plain_hue(), plain_hue(),
                               $urandom_range(0, 255)));
          end
          lim = cfg_sh.arm_loading ? int'(cfg_sh.arm_jam_ticks) : int'(cfg_sh.jam_ticks);
          len = $urandom_range(1, (lim + 4 > 60) ? 60 : lim + 4);
          for (j = 0; j < len; j++) begin
            push_req(tick_item(stall_speed(), plain_hue(), plain_hue(),
                               $urandom_range(0, 255)));
          end
          len = $urandom_range(0, 30);
          for (j = 0; j < len; j++) begin
            if ($urandom_range(0, 19) == 0) begin
              push_req(cmd_item(3'($urandom_range(0, 4))));
            end else begin
              push_req(tick_item($urandom_range(0, 1) ? moving_speed() : stall_speed(),
                                 plain_hue(), plain_hue(), $urandom_range(0, 255)));
            end
          end
        end
        3, 4: begin
          // spin-until, ended by a ring, the timeout or a command
          push_req(cmd_item(MODE_SPIN));
          lim = int'(cfg_sh.spin_timeout_ticks);
          len = $urandom_range(1, (lim + 3 > 40) ? 40 : lim + 3);
          for (j = 0; j < len; j++) begin
            if ($urandom_range(0, 29) == 0) begin
              push_req(cmd_item(3'($urandom_range(0, 4))));
            end else if ($urandom_range(0, 7) == 0) begin
              push_req(tick_item(any_speed(), ring_hue(tc), ring_hue(tc),
                                 $urandom_range(201, 255)));
            end else begin
              push_req(tick_item(any_speed(), plain_hue(), plain_hue(),
                                 $urandom_range(0, 255)));
            end
          end
        end
        5, 6: begin
          // intake running with rings passing the front sensor
          push_req(cmd_item($urandom_range(0, 1) ? MODE_IN : MODE_OUT));
          len = $urandom_range(5, 30);
          for (j = 0; j < len; j++) begin
            if ($urandom_range(0, 3) == 0) begin
              push_req(tick_item(moving_speed(), sort_hue(tc), plain_hue(),
                                 $urandom_range(201, 255)));
            end else begin
              push_req(tick_item(moving_speed(), plain_hue(), plain_hue(),
                                 $urandom_range(0, 255)));
            end
          end
        end
        7: push_req(cmd_item(3'($urandom_range(0, 7))));
        default: begin
          len = $urandom_range(1, 20);
          for (j = 0; j < len; j++) begin
            push_req(tick_item(any_speed(), plain_hue(), plain_hue(),
                               $urandom_range(0, 255)));
          end
        end
      endcase
    end
    wait_drain();
  endtask

  // ------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------
  initial begin
    cfg_sh.team_color         = TEAM_RED;
    cfg_sh.arm_loading        = 1'b0;
    cfg_sh.sorter_hold        = 1'b0;
    cfg_sh.jam_ticks          = 8'd15;
    cfg_sh.arm_jam_ticks      = 10'd100;
    cfg_sh.sort_ticks         = 8'd23;
    cfg_sh.spin_timeout_ticks = 10'd500;
    md         = MODE_IDLE;
    stall_seen = 1'b0;
    stall_cnt  = '0;
    jam_on     = 1'b1;
    sort_since = '0;
    sort_armed = 1'b0;
    spin_on    = 1'b0;
    spin_cnt   = '0;
    rev_hold   = '0;
    sorter_lvl = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: quick jam limit so the reverse hold is reached in a few ticks
    write_reg(CFG_JAM_TICKS, 10'd1);
    @(negedge clk_i);
    push_req(tick_item(0, 250, 100, 255));        // idle, no stall, sort match
    push_req(cmd_item(3'd7));                     // out-of-range mode, ignored
    push_req(cmd_item(MODE_IN));
    push_req(tick_item(600, 0, 359, 0));
    push_req(tick_item(-600, 289, 0, 201));       // hue edge, still a match
    push_req(tick_item(300, 216, 0, 201));        // lowest matching hue
    push_req(tick_item(300, 215, 0, 255));
    push_req(tick_item(-4, 100, 100, 0));         // stall starts
    push_req(tick_item(4, 100, 100, 0));
    push_req(tick_item(0, 100, 100, 0));          // stall limit passed, jam
    push_req(tick_item(600, 250, 250, 255));      // held tick, sorter frozen
    push_req(cmd_item(MODE_OUT));                 // command cuts the hold short
    push_req(tick_item(-5, 0, 0, 0));
    push_req(cmd_item(MODE_SPIN));
    push_req(tick_item(0, 10, 301, 200));         // not near enough, no ring
    push_req(cmd_item(MODE_IN));                  // left by command, jam check off
    push_req(tick_item(0, 10, 10, 0));
    push_req(cmd_item(MODE_SPIN));
    push_req(tick_item(69, 29, 301, 201));        // ring at both sensors
    push_req(cmd_item(MODE_JAM));
    push_req(tick_item(0, 0, 0, 0));              // jam straight from command
    wait_drain();

    // random phases across register settings, extremes included
    write_all(TEAM_RED, 1'b0, 1'b0, 10'd15, 10'd100, 10'd23, 10'd500);
    run_phase(185);
    write_all(TEAM_BLUE, 1'b0, 1'b0, 10'd1, 10'd1, 10'd0, 10'd1);
    run_phase(185);
    write_all(2'd2, 1'b1, 1'b0, 10'd3, 10'd5, 10'd255, 10'd20);
    run_phase(185);
    write_all(2'd3, 1'b0, 1'b1, 10'd255, 10'd1023, 10'd255, 10'd1023);
    run_phase(180);
    write_all(TEAM_BLUE, 1'b1, 1'b1, 10'd8, 10'd12, 10'd10, 10'd40);
    run_phase(185);
    write_all(TEAM_RED, 1'b0, 1'b0, 10'd6, 10'd30, 10'd8, 10'd30);
    run_phase(185);

    repeat (8) @(posedge clk_i);
    if (err_cnt == 0 && intake_results_q.size() == 0) begin
      $display("[intake_jam_sort_controller] OK");
    end else begin
      $display("[intake_jam_sort_controller] ERROR");
    end
    $finish;
  end

endmodule
